@@ src/vwh_pkg.sv @@
// Package for the vertex weld hash table: table sizes, kind and result codes,
// item, result, slot word and controller/datapath handshake types.
// No dependencies; used by every other file of the block.
`default_nettype none

package vwh_pkg;

  // Hash table depth; must be a power of two (home slot is the low key bits)
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned DEPTH_W     = $clog2(TABLE_DEPTH);
  localparam int unsigned INDEX_LIMIT = 4096;
  localparam int unsigned INDEX_W     = $clog2(INDEX_LIMIT);
  localparam int unsigned COUNT_W     = INDEX_W + 1;
  localparam int unsigned CAPACITY    =
      (TABLE_DEPTH < INDEX_LIMIT) ? TABLE_DEPTH : INDEX_LIMIT;
  localparam int unsigned KEY_W       = 32;

  typedef enum logic [1:0] {
    KIND_FIND  = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    RES_ZERO  = 3'd0,
    RES_FOUND = 3'd1,
    RES_NEW   = 3'd2,
    RES_FULL  = 3'd3,
    RES_READ  = 3'd4
  } res_sel_e;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        vertex_index;
    logic [7:0]         tex_u;
    logic [7:0]         tex_v;
    logic [INDEX_W-1:0] entry_number;
  } item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] new_index;
    logic               is_new;
    logic               table_full;
    logic [15:0]        stored_vertex;
    logic [7:0]         stored_u;
    logic [7:0]         stored_v;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   key;
    logic [INDEX_W-1:0] value;
  } slot_word_t;

  // Controller to datapath
  typedef struct packed {
    logic     accept;
    logic     advance;
    logic     sweep;
    logic     count_clear;
    logic     publish;
    res_sel_e res_sel;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic empty;
    logic last_probe;
    logic room;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ src/vwh_if.sv @@
// Valid/ready channel interfaces for corner items and weld results.
// Depends on vwh_pkg for widths.
`default_nettype none

interface vwh_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [15:0]                vertex_index;
  logic [7:0]                 tex_u;
  logic [7:0]                 tex_v;
  logic [vwh_pkg::INDEX_W-1:0] entry_number;

  modport source (output valid, kind, vertex_index, tex_u, tex_v, entry_number,
                  input ready);
  modport sink (input valid, kind, vertex_index, tex_u, tex_v, entry_number,
                output ready);
endinterface

interface vwh_out_if;
  logic                        valid;
  logic                        ready;
  logic [vwh_pkg::INDEX_W-1:0] new_index;
  logic                        is_new;
  logic                        table_full;
  logic [15:0]                 stored_vertex;
  logic [7:0]                  stored_u;
  logic [7:0]                  stored_v;
  logic [vwh_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, new_index, is_new, table_full, stored_vertex,
                  stored_u, stored_v, entry_count, input ready);
  modport sink (input valid, new_index, is_new, table_full, stored_vertex,
                stored_u, stored_v, entry_count, output ready);
endinterface

`default_nettype wire

@@ src/vertex_weld_hash_table.sv @@
// Find/insert: accept, then a probe step per slot visited (linear probing
// over the slot memory); a free home slot needs a single probe step.
// Read: accept, publish. Clear: accept, sweep (1 slot per cycle), publish.
// Result shows in the output register the cycle after the final step.
// Reset: asynchronous, active low; then a pass over all 4096 slots clears
// the valid bits, and no transaction is accepted until it ends.
// Top level; depends on vwh_pkg, vwh_if, vwh_ctrl, vwh_dp.
`default_nettype none

module vertex_weld_hash_table (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  vwh_in_if.sink    in_i,
  vwh_out_if.source out_o
);

  vwh_pkg::cmd_t    cmd;
  vwh_pkg::status_t status;
  vwh_pkg::item_t   item;
  vwh_pkg::result_t result;
  logic             in_ready;
  logic             out_valid;

  // Gather the input transaction
  assign item = '{kind:         in_i.kind,
                  vertex_index: in_i.vertex_index,
                  tex_u:        in_i.tex_u,
                  tex_v:        in_i.tex_v,
                  entry_number: in_i.entry_number};
  assign in_i.ready = in_ready;

  vwh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vwh_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready)
  );

  // Drive the result transaction
  assign out_o.valid         = out_valid;
  assign out_o.new_index     = result.new_index;
  assign out_o.is_new        = result.is_new;
  assign out_o.table_full    = result.table_full;
  assign out_o.stored_vertex = result.stored_vertex;
  assign out_o.stored_u      = result.stored_u;
  assign out_o.stored_v      = result.stored_v;
  assign out_o.entry_count   = result.entry_count;

endmodule

`default_nettype wire

@@ src/vwh_ctrl.sv @@
// Sequencer of the weld table: init sweep, probing, read back, clear.
// Depends on vwh_pkg; drives the datapath vwh_dp through cmd_t/status_t.
`default_nettype none

module vwh_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [1:0]       in_kind_i,
  output logic                  in_ready_o,
  input  wire vwh_pkg::status_t status_i,
  output vwh_pkg::cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_PROBE  = 6'b000100,
    ST_READ   = 6'b001000,
    ST_CLEAR  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = vwh_pkg::RES_ZERO;
    in_ready_o    = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (in_kind_i)
            vwh_pkg::KIND_FIND:  state_d = ST_PROBE;
            vwh_pkg::KIND_CLEAR: state_d = ST_CLEAR;
            vwh_pkg::KIND_READ:  state_d = ST_READ;
            default:             state_d = ST_FINISH;
          endcase
        end
      end
      ST_PROBE: begin
        // Terminal outcomes wait for the output register; misses step on
        priority if (status_i.empty) begin
          if (status_i.out_free) begin
            cmd_o.publish = 1'b1;
            cmd_o.res_sel = status_i.room ? vwh_pkg::RES_NEW : vwh_pkg::RES_FULL;
            state_d       = ST_IDLE;
          end
        end else if (status_i.hit) begin
          if (status_i.out_free) begin
            cmd_o.publish = 1'b1;
            cmd_o.res_sel = vwh_pkg::RES_FOUND;
            state_d       = ST_IDLE;
          end
        end else if (status_i.last_probe) begin
          if (status_i.out_free) begin
            cmd_o.publish = 1'b1;
            cmd_o.res_sel = vwh_pkg::RES_FULL;
            state_d       = ST_IDLE;
          end
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_READ: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          cmd_o.res_sel = vwh_pkg::RES_READ;
          state_d       = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
        if (status_i.sweep_last) begin
          cmd_o.count_clear = 1'b1;
          state_d           = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  // State register; reset starts the valid-bit sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  default clocking cb @(posedge clk_i); endclocking

  a_publish_needs_room: assert property (disable iff (!rst_ni)
    cmd_o.publish |-> status_i.out_free)
    else $error("result published while output register busy");

  a_find_goes_probe: assert property (disable iff (!rst_ni)
    (state_q == ST_IDLE && in_valid_i && in_kind_i == vwh_pkg::KIND_FIND)
      |=> state_q == ST_PROBE)
    else $error("accepted find transaction did not start probing");

endmodule

`default_nettype wire

@@ src/vwh_dp.sv @@
// Datapath of the weld table: slot memory, reverse key memory, probe
// position, counters and the output register. Depends on vwh_pkg.
`default_nettype none

module vwh_dp (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire vwh_pkg::item_t   item_i,
  input  wire vwh_pkg::cmd_t    cmd_i,
  output vwh_pkg::status_t      status_o,
  output vwh_pkg::result_t      result_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i
);

  localparam int unsigned DW = vwh_pkg::DEPTH_W;
  localparam int unsigned IW = vwh_pkg::INDEX_W;
  localparam int unsigned CW = vwh_pkg::COUNT_W;
  localparam int unsigned KW = vwh_pkg::KEY_W;

  vwh_pkg::slot_word_t slot_mem [vwh_pkg::TABLE_DEPTH];
  logic [KW-1:0]       rev_mem  [vwh_pkg::INDEX_LIMIT];

  vwh_pkg::slot_word_t slot_rd_q;
  logic [KW-1:0]       rev_rd_q;
  logic [KW-1:0]       key_q;
  logic [IW-1:0]       entry_q;
  logic [DW-1:0]       pos_q, pos_d;
  logic [DW-1:0]       probe_q;
  logic [DW-1:0]       sweep_q;
  logic [CW-1:0]       count_q, count_d;
  logic                out_valid_q;
  vwh_pkg::result_t    result_q, result_d;

  logic [KW-1:0] in_key;
  logic [DW-1:0] slot_raddr;
  logic [IW-1:0] rev_raddr;
  logic          insert;

  assign in_key = {item_i.vertex_index, item_i.tex_u, item_i.tex_v};
  assign insert = cmd_i.publish && (cmd_i.res_sel == vwh_pkg::RES_NEW);

  // Select the probe address: home slot on accept, next slot on a miss
  always_comb begin
    priority if (cmd_i.accept) begin
      pos_d = in_key[DW-1:0];
    end else if (cmd_i.advance) begin
      pos_d = DW'(pos_q + 1'b1);
    end else begin
      pos_d = pos_q;
    end
  end
  assign slot_raddr = pos_d;
  assign rev_raddr  = cmd_i.accept ? item_i.entry_number : entry_q;

  // Slot memory: sweep clears valid, insert stores key and index
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep) begin
      slot_mem[sweep_q] <= '0;
    end else if (insert) begin
      slot_mem[pos_q] <= '{valid: 1'b1, key: key_q, value: count_q[IW-1:0]};
    end
    slot_rd_q <= slot_mem[slot_raddr];
  end

  // Reverse store: key by new index
  always_ff @(posedge clk_i) begin
    if (insert) begin
      rev_mem[count_q[IW-1:0]] <= key_q;
    end
    rev_rd_q <= rev_mem[rev_raddr];
  end

  // Hold the item under work
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q   <= in_key;
      entry_q <= item_i.entry_number;
    end
    pos_q <= pos_d;
  end

  // Count of welded vertices
  always_comb begin
    priority if (cmd_i.count_clear) begin
      count_d = '0;
    end else if (insert) begin
      count_d = CW'(count_q + 1'b1);
    end else begin
      count_d = count_q;
    end
  end

  // Probe and sweep counters, vertex count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
      sweep_q <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        probe_q <= '0;
      end else if (cmd_i.advance) begin
        probe_q <= DW'(probe_q + 1'b1);
      end
      if (cmd_i.sweep) begin
        sweep_q <= DW'(sweep_q + 1'b1);
      end
      count_q <= count_d;
    end
  end

  // Assemble the result transaction
  always_comb begin
    result_d             = '0;
    result_d.entry_count = count_d;
    unique case (cmd_i.res_sel)
      vwh_pkg::RES_ZERO: ;
      vwh_pkg::RES_FOUND: result_d.new_index = slot_rd_q.value;
      vwh_pkg::RES_NEW: begin
        result_d.new_index = count_q[IW-1:0];
        result_d.is_new    = 1'b1;
      end
      vwh_pkg::RES_FULL: result_d.table_full = 1'b1;
      vwh_pkg::RES_READ: begin
        result_d.new_index = entry_q;
        if ({1'b0, entry_q} < count_q) begin
          result_d.stored_vertex = rev_rd_q[31:16];
          result_d.stored_u      = rev_rd_q[15:8];
          result_d.stored_v      = rev_rd_q[7:0];
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // Status back to the sequencer
  assign status_o.empty      = !slot_rd_q.valid;
  assign status_o.hit        = slot_rd_q.valid && (slot_rd_q.key == key_q);
  assign status_o.last_probe = (probe_q == DW'(vwh_pkg::TABLE_DEPTH - 1));
  assign status_o.room       = (count_q < CW'(vwh_pkg::CAPACITY));
  assign status_o.sweep_last = (sweep_q == DW'(vwh_pkg::TABLE_DEPTH - 1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  default clocking cb @(posedge clk_i); endclocking

  a_insert_into_empty: assert property (disable iff (!rst_ni)
    insert |-> !slot_rd_q.valid)
    else $error("insert over an occupied slot");

  a_count_bounded: assert property (disable iff (!rst_ni)
    count_q <= CW'(vwh_pkg::CAPACITY))
    else $error("vertex count beyond capacity");

  a_publish_shows: assert property (disable iff (!rst_ni)
    cmd_i.publish |=> out_valid_q)
    else $error("published result not presented");

endmodule

`default_nettype wire
